/* sv/nmp_pkg.sv */
package nmp_pkg;

  localparam int unsigned HDR_LEN = 7;

  typedef enum logic [3:0] {
    PH_SIZE, PH_TYPE, PH_TAG, PH_FIX, PH_SLEN, PH_SBYTE, PH_QT, PH_QV,
    PH_QP, PH_PLEN, PH_PBYTE, PH_WCNT, PH_DONE, PH_HALT
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK, ST_SHORT, ST_BAD_SIZE, ST_BAD_TYPE, ST_TOO_MANY, ST_MISMATCH
  } status_e;

  // body operation kinds (upper three bits of an op byte)
  localparam logic [2:0] K_END = 3'd0;
  localparam logic [2:0] K_FIX = 3'd1;
  localparam logic [2:0] K_STR = 3'd2;
  localparam logic [2:0] K_QID = 3'd3;
  localparam logic [2:0] K_PAY = 3'd4;
  localparam logic [2:0] K_WN  = 3'd5;
  localparam logic [2:0] K_WQ  = 3'd6;

  localparam logic [4:0] F_SIZE = 5'd0;
  localparam logic [4:0] F_TYPE = 5'd1;
  localparam logic [4:0] F_TAG = 5'd2;
  localparam logic [4:0] F_NWNAME = 5'd8;
  localparam logic [4:0] F_COUNT = 5'd12;
  localparam logic [4:0] F_NSTAT = 5'd13;
  localparam logic [4:0] F_NWQID = 5'd14;
  localparam logic [4:0] F_QTYPE = 5'd16;
  localparam logic [4:0] F_QVERS = 5'd17;
  localparam logic [4:0] F_QPATH = 5'd18;
  localparam logic [4:0] F_SLEN = 5'd19;
  localparam logic [4:0] F_SBYTE = 5'd20;
  localparam logic [4:0] F_DBYTE = 5'd21;
  localparam logic [4:0] F_STBYTE = 5'd22;
  localparam logic [4:0] F_VERDICT = 5'd23;

  localparam logic [2:0] SLOT_WNAME = 3'd3;

  typedef struct packed {
    logic [4:0]  field_id;
    logic [63:0] field_value;
    logic [2:0]  string_slot;
    logic [3:0]  element_index;
    logic [7:0]  message_type;
    logic        is_verdict;
    logic [2:0]  status;
    logic [31:0] message_size;
    logic        last_result;
  } res_t;

  function automatic logic type_known(input logic [7:0] t);
    return (t inside {[8'd100:8'd127]}) && (t != 8'd106);
  endfunction

  function automatic logic [7:0] mk(input logic [2:0] k, input logic [4:0] a);
    return {k, a};
  endfunction

  function automatic logic [7:0] body_op(input logic [7:0] t, input logic [2:0] idx);
    logic [7:0] p0, p1, p2, p3;
    p0 = '0; p1 = '0; p2 = '0; p3 = '0;
    case (t)
      8'd100, 8'd101: begin p0 = mk(K_FIX, 5'd3); p1 = mk(K_STR, 5'd0); end
      8'd102: begin p0 = mk(K_FIX, 5'd5); p1 = mk(K_STR, 5'd1); p2 = mk(K_STR, 5'd2); end
      8'd103, 8'd105: p0 = mk(K_QID, 5'd0);
      8'd104: begin
        p0 = mk(K_FIX, 5'd6); p1 = mk(K_FIX, 5'd5);
        p2 = mk(K_STR, 5'd1); p3 = mk(K_STR, 5'd2);
      end
      8'd107: p0 = mk(K_STR, 5'd5);
      8'd108: p0 = mk(K_FIX, 5'd4);
      8'd110: begin p0 = mk(K_FIX, 5'd6); p1 = mk(K_FIX, 5'd7); p2 = mk(K_WN, 5'd0); end
      8'd111: p0 = mk(K_WQ, 5'd0);
      8'd112: begin p0 = mk(K_FIX, 5'd6); p1 = mk(K_FIX, 5'd9); end
      8'd113, 8'd115: begin p0 = mk(K_QID, 5'd0); p1 = mk(K_FIX, 5'd15); end
      8'd114: begin
        p0 = mk(K_FIX, 5'd6); p1 = mk(K_STR, 5'd4);
        p2 = mk(K_FIX, 5'd10); p3 = mk(K_FIX, 5'd9);
      end
      8'd116: begin p0 = mk(K_FIX, 5'd6); p1 = mk(K_FIX, 5'd11); p2 = mk(K_FIX, 5'd12); end
      8'd117: p0 = mk(K_PAY, 5'd0);
      8'd118: begin p0 = mk(K_FIX, 5'd6); p1 = mk(K_FIX, 5'd11); p2 = mk(K_PAY, 5'd0); end
      8'd119: p0 = mk(K_FIX, 5'd12);
      8'd120, 8'd122, 8'd124: p0 = mk(K_FIX, 5'd6);
      8'd125: p0 = mk(K_PAY, 5'd1);
      8'd126: begin p0 = mk(K_FIX, 5'd6); p1 = mk(K_PAY, 5'd1); end
      default: ;
    endcase
    case (idx)
      3'd0: return p0;
      3'd1: return p1;
      3'd2: return p2;
      3'd3: return p3;
      default: return '0;
    endcase
  endfunction

  function automatic logic [3:0] fix_width(input logic [3:0] a);
    case (a)
      4'd1, 4'd9: return 4'd1;
      4'd2, 4'd4, 4'd8, 4'd13, 4'd14: return 4'd2;
      4'd11: return 4'd8;
      default: return 4'd4;
    endcase
  endfunction

  function automatic logic [3:0] phase_width(input phase_e ph, input logic [7:0] op);
    case (ph)
      PH_SIZE: return 4'd4;
      PH_TAG, PH_SLEN, PH_WCNT: return 4'd2;
      PH_FIX: return fix_width(op[3:0]);
      PH_QV: return 4'd4;
      PH_QP: return 4'd8;
      PH_PLEN: return op[0] ? 4'd2 : 4'd4;
      default: return 4'd1;
    endcase
  endfunction

endpackage

/* sv/nmp_in_if.sv */
interface nmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

/* sv/nmp_out_if.sv */
interface nmp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_id;
  logic [63:0] field_value;
  logic [2:0]  string_slot;
  logic [3:0]  element_index;
  logic [7:0]  message_type;
  logic        is_verdict;
  logic [2:0]  status;
  logic [31:0] message_size;
  logic        last_result;
  modport source (output valid, field_id, field_value, string_slot, element_index,
                  message_type, is_verdict, status, message_size, last_result,
                  input ready);
  modport sink (input valid, field_id, field_value, string_slot, element_index,
                message_type, is_verdict, status, message_size, last_result,
                output ready);
endinterface

/* sv/nmp_res_fifo.sv */
module nmp_res_fifo import nmp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push0_i,
  input  res_t data0_i,
  input  logic push1_i,
  input  res_t data1_i,
  output logic room_o,
  output logic valid_o,
  output res_t data_o,
  input  logic pop_i
);
  res_t       mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic [1:0] wr1;
  logic [2:0] npush;

  assign valid_o = cnt_q != 3'd0;
  assign data_o  = mem_q[rd_q];
  assign room_o  = cnt_q <= 3'd2;
  assign wr1     = push0_i ? wr_q + 2'd1 : wr_q;
  assign npush   = {2'b00, push0_i} + {2'b00, push1_i};

  always_ff @(posedge clk_i) begin
    if (push0_i) mem_q[wr_q] <= data0_i;
    if (push1_i) mem_q[wr1] <= data1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + npush[1:0];
      if (pop_i && valid_o) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + npush - {2'b00, pop_i && valid_o};
    end
  end
endmodule

/* sv/ninep_message_parser.sv */
// 9P2000 message parser, one byte per transaction.
// Each accepted byte's results are written into the result queue, whose head is the output.
// Throughput: one byte per cycle while the queue has room; the input stalls while three
// or more results are queued, and a byte with both a field and a verdict gives two results.
// Reset: asynchronous, active low; clears parse state and the result queue.
module ninep_message_parser import nmp_pkg::*; #(
  parameter int unsigned MAX_WALK_ELEMENTS = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input logic clk_i,
  input logic rst_ni,
  nmp_in_if.sink    in_i,
  nmp_out_if.source out_o
);
  phase_e                   phase_q, phase_d;
  logic [3:0]               bif_q, bif_d;
  logic [63:0]              acc_q, acc_d;
  logic [31:0]              dsize_q, dsize_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [31:0]              rem_q, rem_d;
  logic [4:0]               etot_q, etot_d, ecnt_q, ecnt_d;
  logic [7:0]               type_q, type_d;
  status_e                  err_q, err_d;
  logic [2:0]               opi_q, opi_d;

  logic fire, room;
  logic push0, push1;
  res_t r0, r1, head;

  assign fire = in_i.valid && in_i.ready;
  assign in_i.ready = room;

  always_comb begin
    logic [7:0]  op, op2, b;
    logic [2:0]  kind;
    logic [63:0] acc_new, v;
    logic [3:0]  bif_new;
    logic        emit, do_start, done_item, done_field;
    logic [3:0]  elem;
    logic [31:0] pos32;
    status_e     st;

    phase_d = phase_q; bif_d = bif_q; acc_d = acc_q; dsize_d = dsize_q;
    pos_d = pos_q; rem_d = rem_q; etot_d = etot_q; ecnt_d = ecnt_q;
    type_d = type_q; err_d = err_q; opi_d = opi_q;
    r0 = '0; r1 = '0; emit = 1'b0; do_start = 1'b0; done_item = 1'b0;
    done_field = 1'b0; push0 = 1'b0; push1 = 1'b0; st = ST_OK; v = '0;
    b = in_i.data_byte;
    op = body_op(type_q, opi_q);
    kind = op[7:5];
    elem = (kind == K_WN || kind == K_WQ) ? ecnt_q[3:0] : 4'd0;
    acc_new = acc_q | ({56'd0, b} << {bif_q[2:0], 3'b000});
    bif_new = bif_q + 4'd1;
    op2 = '0;
    pos32 = '0;

    if (fire) begin
      if (pos_q != '1) pos_d = pos_q + 1'b1;
      if (phase_q == PH_SBYTE || phase_q == PH_PBYTE) begin
        emit = 1'b1;
        r0.field_value = {56'd0, b};
        if (phase_q == PH_SBYTE) begin
          r0.field_id = F_SBYTE;
          r0.string_slot = (kind == K_WN) ? SLOT_WNAME : op[2:0];
          r0.element_index = elem;
        end else begin
          r0.field_id = op[0] ? F_STBYTE : F_DBYTE;
        end
        rem_d = rem_q - 32'd1;
        if (rem_d == 32'd0) begin
          if (phase_q == PH_SBYTE) done_item = 1'b1;
          else begin opi_d = opi_q + 3'd1; do_start = 1'b1; end
        end
      end else if (phase_q < PH_DONE) begin
        if (bif_new >= phase_width(phase_q, op)) begin
          done_field = 1'b1; v = acc_new; acc_d = '0; bif_d = '0;
        end else begin
          acc_d = acc_new; bif_d = bif_new;
        end
      end

      if (done_field) begin
        emit = 1'b1;
        r0.field_value = v;
        case (phase_q)
          PH_SIZE: begin
            r0.field_id = F_SIZE;
            dsize_d = v[31:0];
            if (v[31:0] < 32'(HDR_LEN)) begin err_d = ST_BAD_SIZE; phase_d = PH_HALT; end
            else phase_d = PH_TYPE;
          end
          PH_TYPE: begin
            r0.field_id = F_TYPE;
            type_d = v[7:0];
            if (!type_known(v[7:0])) begin err_d = ST_BAD_TYPE; phase_d = PH_HALT; end
            else phase_d = PH_TAG;
          end
          PH_TAG: begin
            r0.field_id = F_TAG; opi_d = 3'd0; do_start = 1'b1;
          end
          PH_FIX: begin
            r0.field_id = op[4:0]; opi_d = opi_q + 3'd1; do_start = 1'b1;
          end
          PH_SLEN: begin
            r0.field_id = F_SLEN;
            r0.string_slot = (kind == K_WN) ? SLOT_WNAME : op[2:0];
            r0.element_index = elem;
            rem_d = v[31:0];
            if (v[31:0] == 32'd0) done_item = 1'b1;
            else phase_d = PH_SBYTE;
          end
          PH_QT: begin r0.field_id = F_QTYPE; r0.element_index = elem; phase_d = PH_QV; end
          PH_QV: begin r0.field_id = F_QVERS; r0.element_index = elem; phase_d = PH_QP; end
          PH_QP: begin r0.field_id = F_QPATH; r0.element_index = elem; done_item = 1'b1; end
          PH_PLEN: begin
            r0.field_id = op[0] ? F_NSTAT : F_COUNT;
            rem_d = v[31:0];
            if (v[31:0] == 32'd0) begin opi_d = opi_q + 3'd1; do_start = 1'b1; end
            else phase_d = PH_PBYTE;
          end
          PH_WCNT: begin
            r0.field_id = (kind == K_WN) ? F_NWNAME : F_NWQID;
            if (v > 64'(MAX_WALK_ELEMENTS)) begin
              err_d = ST_TOO_MANY; phase_d = PH_HALT;
            end else begin
              etot_d = v[4:0]; ecnt_d = '0;
              if (v[4:0] == 5'd0) begin opi_d = opi_q + 3'd1; do_start = 1'b1; end
              else phase_d = (kind == K_WN) ? PH_SLEN : PH_QT;
            end
          end
          default: ;
        endcase
      end

      if (done_item) begin
        if (kind == K_WN || kind == K_WQ) begin
          ecnt_d = ecnt_q + 5'd1;
          if (ecnt_d < etot_q) phase_d = (kind == K_WN) ? PH_SLEN : PH_QT;
          else begin opi_d = opi_q + 3'd1; do_start = 1'b1; end
        end else begin
          opi_d = opi_q + 3'd1; do_start = 1'b1;
        end
      end

      pos32 = 32'(pos_d);
      if (do_start) begin
        op2 = body_op(type_d, opi_d);
        case (op2[7:5])
          K_FIX: phase_d = PH_FIX;
          K_STR: phase_d = PH_SLEN;
          K_QID: phase_d = PH_QT;
          K_PAY: phase_d = PH_PLEN;
          K_WN, K_WQ: phase_d = PH_WCNT;
          default: begin
            phase_d = PH_DONE;
            if (pos32 != dsize_d) err_d = ST_MISMATCH;
          end
        endcase
      end

      r0.message_type = type_d;
      r0.last_result = !in_i.last_byte;
      push0 = emit;

      if (in_i.last_byte) begin
        if (pos32 < 32'(HDR_LEN)) st = ST_SHORT;
        else if (dsize_d < 32'(HDR_LEN) || dsize_d > pos32) st = ST_BAD_SIZE;
        else if (err_d != ST_OK) st = err_d;
        else if (phase_d != PH_DONE) st = ST_SHORT;
        else st = ST_OK;
        r1.field_id = F_VERDICT;
        r1.message_type = type_d;
        r1.is_verdict = 1'b1;
        r1.status = st;
        r1.message_size = (st == ST_OK) ? dsize_d : 32'd0;
        r1.last_result = 1'b1;
        if (emit) push1 = 1'b1;
        else begin r0 = r1; push0 = 1'b1; end
        phase_d = PH_SIZE; bif_d = '0; acc_d = '0; dsize_d = '0; pos_d = '0;
        rem_d = '0; etot_d = '0; ecnt_d = '0; type_d = '0; err_d = ST_OK;
        opi_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE; bif_q <= '0; acc_q <= '0; dsize_q <= '0; pos_q <= '0;
      rem_q <= '0; etot_q <= '0; ecnt_q <= '0; type_q <= '0; err_q <= ST_OK;
      opi_q <= '0;
    end else begin
      phase_q <= phase_d; bif_q <= bif_d; acc_q <= acc_d; dsize_q <= dsize_d;
      pos_q <= pos_d; rem_q <= rem_d; etot_q <= etot_d; ecnt_q <= ecnt_d;
      type_q <= type_d; err_q <= err_d; opi_q <= opi_d;
    end
  end

  nmp_res_fifo u_fifo (
    .clk_i, .rst_ni,
    .push0_i(push0), .data0_i(r0),
    .push1_i(push1), .data1_i(r1),
    .room_o(room),
    .valid_o(out_o.valid), .data_o(head),
    .pop_i(out_o.ready)
  );

  assign out_o.field_id      = head.field_id;
  assign out_o.field_value   = head.field_value;
  assign out_o.string_slot   = head.string_slot;
  assign out_o.element_index = head.element_index;
  assign out_o.message_type  = head.message_type;
  assign out_o.is_verdict    = head.is_verdict;
  assign out_o.status        = head.status;
  assign out_o.message_size  = head.message_size;
  assign out_o.last_result   = head.last_result;
endmodule

/* sv/nmp_checker.sv */
module nmp_checker import nmp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  field_id,
  input logic        is_verdict,
  input logic [2:0]  status,
  input logic [31:0] message_size,
  input logic        last_result
);
  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && is_verdict |-> last_result && field_id == F_VERDICT)
    else $error("verdict not marked last");

  a_plain_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !is_verdict |-> status == ST_OK && message_size == 32'd0)
    else $error("non-verdict carries status");

  a_ok_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && is_verdict && status == ST_OK |-> message_size >= 32'(HDR_LEN))
    else $error("ok verdict with short size");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(field_id) && $stable(is_verdict))
    else $error("stalled transaction changed");
endmodule

bind ninep_message_parser nmp_checker u_nmp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .field_id(out_o.field_id), .is_verdict(out_o.is_verdict),
  .status(out_o.status), .message_size(out_o.message_size),
  .last_result(out_o.last_result)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import nmp_pkg::*;

  localparam int unsigned MAX_WALK = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Byte-level predictor of the 9P message parser plus a queue of expected rows.
  class parse_scoreboard;
    phase_e      phase;
    int unsigned bif;
    logic [63:0] acc;
    logic [31:0] dsize;
    logic [31:0] pos;
    logic [31:0] remain;
    int unsigned el_total, el_cnt;
    logic [7:0]  mtype;
    logic [2:0]  err;
    int unsigned op_idx;
    res_t        pending_rows[$];
    res_t        step_rows[$];
    int          mismatches;
    int          rows_seen;
    int          verdicts_seen;

    function void clear_state();
      phase = PH_SIZE; bif = 0; acc = '0; dsize = '0; pos = '0; remain = '0;
      el_total = 0; el_cnt = 0; mtype = '0; err = '0; op_idx = 0;
    endfunction

    function logic [7:0] cur_op();
      if (op_idx >= 4 || !((mtype >= 100) && (mtype <= 127) && (mtype != 106))) return 8'd0;
      case (mtype)
        8'd100, 8'd101: return op_idx == 0 ? {K_FIX, 5'd3} : op_idx == 1 ? {K_STR, 5'd0} : 8'd0;
        8'd102: return op_idx == 0 ? {K_FIX, 5'd5} : op_idx == 1 ? {K_STR, 5'd1} :
                       op_idx == 2 ? {K_STR, 5'd2} : 8'd0;
        8'd103, 8'd105: return op_idx == 0 ? {K_QID, 5'd0} : 8'd0;
        8'd104: return op_idx == 0 ? {K_FIX, 5'd6} : op_idx == 1 ? {K_FIX, 5'd5} :
                       op_idx == 2 ? {K_STR, 5'd1} : {K_STR, 5'd2};
        8'd107: return op_idx == 0 ? {K_STR, 5'd5} : 8'd0;
        8'd108: return op_idx == 0 ? {K_FIX, 5'd4} : 8'd0;
        8'd110: return op_idx == 0 ? {K_FIX, 5'd6} : op_idx == 1 ? {K_FIX, 5'd7} :
                       op_idx == 2 ? {K_WN, 5'd0} : 8'd0;
        8'd111: return op_idx == 0 ? {K_WQ, 5'd0} : 8'd0;
        8'd112: return op_idx == 0 ? {K_FIX, 5'd6} : op_idx == 1 ? {K_FIX, 5'd9} : 8'd0;
        8'd113, 8'd115: return op_idx == 0 ? {K_QID, 5'd0} : op_idx == 1 ? {K_FIX, 5'd15} : 8'd0;
        8'd114: return op_idx == 0 ? {K_FIX, 5'd6} : op_idx == 1 ? {K_STR, 5'd4} :
                       op_idx == 2 ? {K_FIX, 5'd10} : {K_FIX, 5'd9};
        8'd116: return op_idx == 0 ? {K_FIX, 5'd6} : op_idx == 1 ? {K_FIX, 5'd11} :
                       op_idx == 2 ? {K_FIX, 5'd12} : 8'd0;
        8'd117: return op_idx == 0 ? {K_PAY, 5'd0} : 8'd0;
        8'd118: return op_idx == 0 ? {K_FIX, 5'd6} : op_idx == 1 ? {K_FIX, 5'd11} :
                       op_idx == 2 ? {K_PAY, 5'd0} : 8'd0;
        8'd119: return op_idx == 0 ? {K_FIX, 5'd12} : 8'd0;
        8'd120, 8'd122, 8'd124: return op_idx == 0 ? {K_FIX, 5'd6} : 8'd0;
        8'd125: return op_idx == 0 ? {K_PAY, 5'd1} : 8'd0;
        8'd126: return op_idx == 0 ? {K_FIX, 5'd6} : op_idx == 1 ? {K_PAY, 5'd1} : 8'd0;
        default: return 8'd0;
      endcase
    endfunction

    function int unsigned width_now();
      logic [7:0] op;
      op = cur_op();
      case (phase)
        PH_SIZE, PH_QV: return 4;
        PH_TAG, PH_SLEN, PH_WCNT: return 2;
        PH_QP: return 8;
        PH_PLEN: return op[0] ? 2 : 4;
        PH_FIX: begin
          case (op[3:0])
            4'd1, 4'd9: return 1;
            4'd2, 4'd4, 4'd8, 4'd13, 4'd14: return 2;
            4'd11: return 8;
            default: return 4;
          endcase
        end
        default: return 1;
      endcase
    endfunction

    function void add_row(logic [4:0] id, logic [63:0] v, logic [2:0] slot, logic [3:0] el);
      res_t r;
      r = '0;
      r.field_id = id; r.field_value = v; r.string_slot = slot;
      r.element_index = el; r.message_type = mtype;
      step_rows.push_back(r);
    endfunction

    function void start_op();
      case (cur_op()[7:5])
        K_FIX: phase = PH_FIX;
        K_STR: phase = PH_SLEN;
        K_QID: phase = PH_QT;
        K_PAY: phase = PH_PLEN;
        K_WN, K_WQ: phase = PH_WCNT;
        default: begin
          phase = PH_DONE;
          if (pos != dsize) err = ST_MISMATCH;
        end
      endcase
    endfunction

    function void advance_op();
      op_idx++;
      start_op();
    endfunction

    function void element_done();
      logic [2:0] k;
      k = cur_op()[7:5];
      if (k == K_WN || k == K_WQ) begin
        el_cnt++;
        if (el_cnt < el_total) begin
          phase = (k == K_WN) ? PH_SLEN : PH_QT;
          return;
        end
      end
      advance_op();
    endfunction

    function logic [3:0] elem_now();
      logic [2:0] k;
      k = cur_op()[7:5];
      return (k == K_WN || k == K_WQ) ? el_cnt[3:0] : 4'd0;
    endfunction

    function logic [2:0] slot_now();
      logic [7:0] op;
      op = cur_op();
      return (op[7:5] == K_WN) ? SLOT_WNAME : op[2:0];
    endfunction

    function void field_done(logic [63:0] v);
      logic [7:0] op;
      op = cur_op();
      case (phase)
        PH_SIZE: begin
          dsize = v[31:0];
          add_row(F_SIZE, v, 0, 0);
          if (dsize < HDR_LEN) begin err = ST_BAD_SIZE; phase = PH_HALT; end
          else phase = PH_TYPE;
        end
        PH_TYPE: begin
          mtype = v[7:0];
          add_row(F_TYPE, v, 0, 0);
          if (!((mtype >= 100) && (mtype <= 127) && (mtype != 106))) begin
            err = ST_BAD_TYPE; phase = PH_HALT;
          end else phase = PH_TAG;
        end
        PH_TAG: begin
          add_row(F_TAG, v, 0, 0);
          op_idx = 0;
          start_op();
        end
        PH_FIX: begin
          add_row(op[4:0], v, 0, 0);
          advance_op();
        end
        PH_SLEN: begin
          add_row(F_SLEN, v, slot_now(), elem_now());
          remain = v[31:0];
          if (remain == 0) element_done();
          else phase = PH_SBYTE;
        end
        PH_QT: begin add_row(F_QTYPE, v, 0, elem_now()); phase = PH_QV; end
        PH_QV: begin add_row(F_QVERS, v, 0, elem_now()); phase = PH_QP; end
        PH_QP: begin add_row(F_QPATH, v, 0, elem_now()); element_done(); end
        PH_PLEN: begin
          add_row(op[0] ? F_NSTAT : F_COUNT, v, 0, 0);
          remain = v[31:0];
          if (remain == 0) advance_op();
          else phase = PH_PBYTE;
        end
        PH_WCNT: begin
          add_row(op[7:5] == K_WN ? F_NWNAME : F_NWQID, v, 0, 0);
          if (v > MAX_WALK) begin
            err = ST_TOO_MANY; phase = PH_HALT;
          end else begin
            el_total = v; el_cnt = 0;
            if (el_total == 0) advance_op();
            else phase = (op[7:5] == K_WN) ? PH_SLEN : PH_QT;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [7:0] op;
      logic [2:0] st;
      logic [63:0] v;
      res_t r;
      step_rows.delete();
      if (pos != 32'hFFFF_FFFF) pos++;
      op = cur_op();
      if (phase == PH_SBYTE) begin
        add_row(F_SBYTE, b, slot_now(), elem_now());
        remain--;
        if (remain == 0) element_done();
      end else if (phase == PH_PBYTE) begin
        add_row(op[0] ? F_STBYTE : F_DBYTE, b, 0, 0);
        remain--;
        if (remain == 0) advance_op();
      end else if (phase < PH_DONE) begin
        acc |= 64'(b) << (8 * bif);
        bif++;
        if (bif >= width_now()) begin
          v = acc; acc = '0; bif = 0;
          field_done(v);
        end
      end
      if (last) begin
        if (pos < HDR_LEN) st = ST_SHORT;
        else if (dsize < HDR_LEN || dsize > pos) st = ST_BAD_SIZE;
        else if (err != 0) st = err;
        else if (phase != PH_DONE) st = ST_SHORT;
        else st = ST_OK;
        r = '0;
        r.field_id = F_VERDICT; r.message_type = mtype; r.is_verdict = 1'b1;
        r.status = st; r.message_size = (st == ST_OK) ? dsize : 32'd0;
        step_rows.push_back(r);
        clear_state();
      end
      if (step_rows.size() > 0) step_rows[step_rows.size() - 1].last_result = 1'b1;
      foreach (step_rows[i]) pending_rows.push_back(step_rows[i]);
    endfunction

    function void check_row(res_t got);
      res_t exp;
      rows_seen++;
      if (got.is_verdict) verdicts_seen++;
      if (pending_rows.size() == 0) begin
        $error("unexpected result: field_id %0d value %0h", got.field_id, got.field_value);
        mismatches++;
        return;
      end
      exp = pending_rows.pop_front();
      if (got.field_id !== exp.field_id) begin
        $error("field_id: expected %0d, actual %0d", exp.field_id, got.field_id); mismatches++;
      end
      if (got.field_value !== exp.field_value) begin
        $error("field_value: expected %0h, actual %0h", exp.field_value, got.field_value);
        mismatches++;
      end
      if (got.string_slot !== exp.string_slot) begin
        $error("string_slot: expected %0d, actual %0d", exp.string_slot, got.string_slot);
        mismatches++;
      end
      if (got.element_index !== exp.element_index) begin
        $error("element_index: expected %0d, actual %0d", exp.element_index,
               got.element_index);
        mismatches++;
      end
      if (got.message_type !== exp.message_type) begin
        $error("message_type: expected %0d, actual %0d", exp.message_type, got.message_type);
        mismatches++;
      end
      if (got.is_verdict !== exp.is_verdict) begin
        $error("is_verdict: expected %0d, actual %0d", exp.is_verdict, got.is_verdict);
        mismatches++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status); mismatches++;
      end
      if (got.message_size !== exp.message_size) begin
        $error("message_size: expected %0d, actual %0d", exp.message_size, got.message_size);
        mismatches++;
      end
      if (got.last_result !== exp.last_result) begin
        $error("last_result: expected %0d, actual %0d", exp.last_result, got.last_result);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  nmp_in_if  byte_ch ();
  nmp_out_if res_ch ();

  ninep_message_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch.sink),
    .out_o  (res_ch.source)
  );

  parse_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned bytes_sent;
  int unsigned messages_sent;
  longint unsigned cycle_count;
  logic [7:0] msg_buf[$];

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  always @(posedge clk_i) begin
    res_t got;
    cycle_count <= cycle_count + 1;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.field_id = res_ch.field_id; got.field_value = res_ch.field_value;
      got.string_slot = res_ch.string_slot; got.element_index = res_ch.element_index;
      got.message_type = res_ch.message_type; got.is_verdict = res_ch.is_verdict;
      got.status = res_ch.status; got.message_size = res_ch.message_size;
      got.last_result = res_ch.last_result;
      sb.check_row(got);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stalls, redrawn every falling edge
  always @(negedge clk_i) begin
    if (rst_ni) res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays high after an accepted byte until the next idle cycle or the end
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    sb.note_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < msg_buf.size(); i++) send_byte(msg_buf[i], i == msg_buf.size() - 1);
    messages_sent++;
    msg_buf.delete();
  endtask

  task automatic put_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) msg_buf.push_back(v[8*i +: 8]);
  endtask

  task automatic put_str(input int len);
    put_le(len, 2);
    for (int i = 0; i < len; i++) msg_buf.push_back($urandom());
  endtask

  task automatic put_qid();
    msg_buf.push_back($urandom());
    put_le($urandom(), 4);
    put_le({$urandom(), $urandom()}, 8);
  endtask

  function automatic logic [63:0] rnd_field(int n);
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(3))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    return n == 8 ? v : v & ((64'd1 << (8 * n)) - 1);
  endfunction

  // Build a message of the given type into msg_buf, fix up size (well-formed unless nelem > MAX_WALK).
  task automatic build_message(input logic [7:0] t, input int nelem);
    int body_len;
    int dlen;
    put_le(0, 4);
    msg_buf.push_back(t);
    put_le(rnd_field(2), 2);
    case (t)
      8'd100, 8'd101: begin put_le(rnd_field(4), 4); put_str($urandom_range(4)); end
      8'd102: begin put_le(rnd_field(4), 4); put_str($urandom_range(3)); put_str($urandom_range(3)); end
      8'd103, 8'd105: put_qid();
      8'd104: begin
        put_le(rnd_field(4), 4); put_le(rnd_field(4), 4);
        put_str($urandom_range(3)); put_str($urandom_range(3));
      end
      8'd107: put_str($urandom_range(5));
      8'd108: put_le(rnd_field(2), 2);
      8'd110: begin
        put_le(rnd_field(4), 4); put_le(rnd_field(4), 4); put_le(nelem, 2);
        for (int i = 0; i < nelem && nelem <= MAX_WALK; i++) put_str($urandom_range(2));
      end
      8'd111: begin
        put_le(nelem, 2);
        for (int i = 0; i < nelem && nelem <= MAX_WALK; i++) put_qid();
      end
      8'd112: begin put_le(rnd_field(4), 4); msg_buf.push_back($urandom()); end
      8'd113, 8'd115: begin put_qid(); put_le(rnd_field(4), 4); end
      8'd114: begin
        put_le(rnd_field(4), 4); put_str($urandom_range(3));
        put_le(rnd_field(4), 4); msg_buf.push_back($urandom());
      end
      8'd116: begin put_le(rnd_field(4), 4); put_le(rnd_field(8), 8); put_le(rnd_field(4), 4); end
      8'd117: begin
        // four-byte count, then the data
        dlen = $urandom_range(5);
        put_le(dlen, 4);
        for (int i = 0; i < dlen; i++) msg_buf.push_back($urandom());
      end
      8'd118: begin put_le(rnd_field(4), 4); put_le(rnd_field(8), 8); put_le($urandom_range(4), 4);
        for (int i = 0; i < msg_buf[19]; i++) msg_buf.push_back($urandom());
      end
      8'd119, 8'd120, 8'd122, 8'd124: put_le(rnd_field(4), 4);
      8'd125: put_str($urandom_range(4));
      8'd126: begin put_le(rnd_field(4), 4); put_str($urandom_range(4)); end
      default: ;
    endcase
    body_len = msg_buf.size();
    for (int i = 0; i < 4; i++) msg_buf[i] = body_len >> (8 * i);
  endtask

  task automatic send_message(input logic [7:0] t);
    int mode;
    int nel;
    logic [31:0] sz;
    nel = (t == 8'd110 || t == 8'd111) ?
          ($urandom_range(9) == 0 ? $urandom_range(17, 20) : $urandom_range(4)) : 0;
    build_message(t, nel);
    mode = $urandom_range(19);
    // mostly clean; the rest truncated, padded or with a wrong size
    if (mode == 0 && msg_buf.size() > 1) begin
      repeat ($urandom_range(1, msg_buf.size() - 1)) void'(msg_buf.pop_back());
    end else if (mode == 1) begin
      repeat ($urandom_range(1, 3)) msg_buf.push_back($urandom());
    end else if (mode == 2) begin
      sz = $urandom_range(0, msg_buf.size() + 3);
      for (int i = 0; i < 4; i++) msg_buf[i] = sz >> (8 * i);
    end
    send_buffer();
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    cycle_count = 0;
    bytes_sent = 0;
    messages_sent = 0;
    send_idle_pct = 17;
    recv_idle_pct = 61;
    rst_ni = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    res_ch.ready = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: short buffers, bad sizes, unknown types, Terror, walk limits
    msg_buf = '{8'h00, 8'hFF, 8'h07};
    send_buffer();
    msg_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd100, 8'h00, 8'h00, 8'hAA};
    send_buffer();
    msg_buf = '{8'h03, 8'h00, 8'h00, 8'h00, 8'd120, 8'h00, 8'h00};
    send_buffer();
    msg_buf = '{8'h07, 8'h00, 8'h00, 8'h00, 8'd99, 8'h12, 8'h34};
    send_buffer();
    msg_buf = '{8'h07, 8'h00, 8'h00, 8'h00, 8'd106, 8'h12, 8'h34};
    send_buffer();
    msg_buf = '{8'h07, 8'h00, 8'h00, 8'h00, 8'd128, 8'h00, 8'h00};
    send_buffer();
    msg_buf = '{8'h07, 8'h00, 8'h00, 8'h00, 8'd127, 8'hFF, 8'hFF};
    send_buffer();
    build_message(8'd110, MAX_WALK + 1);
    send_buffer();
    build_message(8'd118, 0);
    send_buffer();

    send_idle_pct = 61;
    recv_idle_pct = 17;
    build_message(8'd110, MAX_WALK);
    send_buffer();
    while (bytes_sent < 210) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 12)) msg_buf.push_back($urandom());
        send_buffer();
      end else begin
        send_message($urandom_range(100, 127));
      end
      if (bytes_sent > 170) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end
    byte_ch.valid <= 1'b0;

    while (sb.pending_rows.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d bytes in %0d buffers; checked %0d results, %0d verdicts",
             bytes_sent, messages_sent, sb.rows_seen, sb.verdicts_seen);
    if (sb.mismatches == 0 && sb.pending_rows.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* ninep_message_parser.f */
sv/nmp_pkg.sv
sv/nmp_in_if.sv
sv/nmp_out_if.sv
sv/nmp_res_fifo.sv
sv/ninep_message_parser.sv
sv/nmp_checker.sv
tb/tb_top.sv
